FILE: sv/clock_page_replacement_defines.svh
// ----------------------------------------------------------------------------
// clock_page_replacement_defines
// assertion macros shared by the clock page replacement modules
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTH
`define CPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define CPR_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("%m: check failed");
`else
`define CPR_ASSERT(name, prop)
`define CPR_ASSERT_RST(name, prop)
`endif
`endif

FILE: sv/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// types and constants of the clock page replacement block
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned FRAME_OUT_W = 6;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 88;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_EVICT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic start;
    logic search;
    logic do_hit;
    logic do_fill;
    logic sweep_init;
    logic sweep_step;
    logic evict_rd;
    logic do_evict;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic scan_end;
    logic rd_pend;
    logic has_free;
    logic ref_at_hand;
  } status_t;

endpackage

FILE: sv/cpr_datapath.sv
// ----------------------------------------------------------------------------
// cpr_datapath
// frame page memory, reference bits, clock hand, counters and result register
// ----------------------------------------------------------------------------
`include "clock_page_replacement_defines.svh"

module cpr_datapath #(
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cpr_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic [cpr_pkg::PAGE_W-1:0]       page_i,
  input  cpr_pkg::cmd_t                    cmd_i,
  output cpr_pkg::status_t                 st_o,
  output logic [cpr_pkg::OUT_TDATA_W-1:0]  out_data_o
);
  import cpr_pkg::*;

  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_FRAMES);

  logic [PAGE_W-1:0]    mem [MAX_FRAMES];
  logic [PAGE_W-1:0]    rdata_q;

  logic [CFG_W-1:0]     cfg_q;
  logic [PAGE_W-1:0]    page_q;
  logic [CW-1:0]        scan_q, scan_d;
  logic [FW-1:0]        rd_idx_q;
  logic                 rd_pend_q;
  logic [CW-1:0]        filled_q, filled_d;
  logic [FW-1:0]        hand_q, hand_d;
  logic [MAX_FRAMES-1:0] ref_q, ref_d;
  logic [TOTAL_W-1:0]   hit_q, hit_d, miss_q, miss_d;

  logic                 res_hit_q, res_ev_q;
  logic [FW-1:0]        res_frame_q;
  logic [PAGE_W-1:0]    res_page_q;

  logic                     out_hit_q, out_ev_q;
  logic [FRAME_OUT_W-1:0]   out_frame_q;
  logic [PAGE_W-1:0]        out_page_q;
  logic [TOTAL_W-1:0]       out_hit_tot_q, out_miss_tot_q;

  logic [CW-1:0]        n_eff, filled;
  logic                 issue, rd_en, wr_en;
  logic [FW-1:0]        rd_addr, wr_addr, hand_next;

  // effective frame count and filled count
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(cfg_q) > 32'(MAX_FRAMES)) begin
      n_eff = MaxCount;
    end else begin
      n_eff = CW'(cfg_q);
    end
    filled = (filled_q < n_eff) ? filled_q : n_eff;
  end

  assign issue     = cmd_i.search && (scan_q != filled);
  assign rd_en     = issue || cmd_i.evict_rd;
  assign rd_addr   = cmd_i.evict_rd ? hand_q : scan_q[FW-1:0];
  assign wr_en     = cmd_i.do_fill || cmd_i.do_evict;
  assign wr_addr   = cmd_i.do_fill ? filled[FW-1:0] : hand_q;
  assign hand_next = ((CW'(hand_q) + CW'(1)) == n_eff) ? '0 : hand_q + FW'(1);

  assign st_o.match       = rd_pend_q && (rdata_q == page_q);
  assign st_o.scan_end    = (scan_q == filled);
  assign st_o.rd_pend     = rd_pend_q;
  assign st_o.has_free    = (filled < n_eff);
  assign st_o.ref_at_hand = ref_q[hand_q];

  // frame page memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= page_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    scan_d   = scan_q;
    filled_d = filled_q;
    hand_d   = hand_q;
    ref_d    = ref_q;
    hit_d    = hit_q;
    miss_d   = miss_q;
    if (cmd_i.start) begin
      scan_d = '0;
    end else if (issue) begin
      scan_d = scan_q + CW'(1);
    end
    if (cmd_i.do_hit) begin
      ref_d[rd_idx_q] = 1'b1;
      hit_d = (hit_q == '1) ? hit_q : hit_q + TOTAL_W'(1);
    end
    if (cmd_i.sweep_init) begin
      hand_d = (CW'(hand_q) < n_eff) ? hand_q : '0;
    end
    if (cmd_i.sweep_step) begin
      ref_d[hand_q] = 1'b0;
      hand_d = hand_next;
    end
    if (wr_en) begin
      ref_d[wr_addr] = 1'b1;
      miss_d = (miss_q == '1) ? miss_q : miss_q + TOTAL_W'(1);
      hand_d = ((CW'(wr_addr) + CW'(1)) == n_eff) ? '0 : wr_addr + FW'(1);
    end
    if (cmd_i.do_fill) begin
      filled_d = filled + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CFG_RESET;
      scan_q    <= '0;
      rd_pend_q <= 1'b0;
      filled_q  <= '0;
      hand_q    <= '0;
      ref_q     <= '0;
      hit_q     <= '0;
      miss_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      scan_q    <= scan_d;
      rd_pend_q <= issue;
      filled_q  <= filled_d;
      hand_q    <= hand_d;
      ref_q     <= ref_d;
      hit_q     <= hit_d;
      miss_q    <= miss_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= page_i;
    end
    if (issue) begin
      rd_idx_q <= scan_q[FW-1:0];
    end
    if (cmd_i.do_hit) begin
      res_hit_q   <= 1'b1;
      res_frame_q <= rd_idx_q;
      res_ev_q    <= 1'b0;
      res_page_q  <= '0;
    end else if (cmd_i.do_fill) begin
      res_hit_q   <= 1'b0;
      res_frame_q <= wr_addr;
      res_ev_q    <= 1'b0;
      res_page_q  <= '0;
    end else if (cmd_i.do_evict) begin
      res_hit_q   <= 1'b0;
      res_frame_q <= wr_addr;
      res_ev_q    <= 1'b1;
      res_page_q  <= rdata_q;
    end
    if (cmd_i.load_out) begin
      out_hit_q      <= res_hit_q;
      out_frame_q    <= FRAME_OUT_W'(res_frame_q);
      out_ev_q       <= res_ev_q;
      out_page_q     <= res_page_q;
      out_hit_tot_q  <= hit_q;
      out_miss_tot_q <= miss_q;
    end
  end

  assign out_data_o = {out_miss_tot_q, out_hit_tot_q, out_page_q, out_ev_q, out_frame_q,
                       out_hit_q};

  `CPR_ASSERT(a_filled_bound, filled_q <= MaxCount)
  `CPR_ASSERT(a_write_in_range, wr_en |-> (CW'(wr_addr) < n_eff))
  `CPR_ASSERT(a_hits_never_drop, hit_q >= $past(hit_q))

endmodule

FILE: sv/cpr_controller.sv
// ----------------------------------------------------------------------------
// cpr_controller
// sequencer for lookup, fill, hand sweep and replacement, owns result valid
// ----------------------------------------------------------------------------
`include "clock_page_replacement_defines.svh"

module cpr_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  cpr_pkg::status_t  st_i,
  output cpr_pkg::cmd_t     cmd_o
);
  import cpr_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   slot_free;

  assign slot_free = !m_valid_q || m_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (st_i.match) begin
          state_d = ST_RESULT;
        end else if (st_i.scan_end && !st_i.rd_pend) begin
          state_d = st_i.has_free ? ST_RESULT : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!st_i.ref_at_hand) begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.start  = s_valid_i;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (st_i.match) begin
          cmd_o.do_hit = 1'b1;
        end else if (st_i.scan_end && !st_i.rd_pend) begin
          cmd_o.do_fill    = st_i.has_free;
          cmd_o.sweep_init = !st_i.has_free;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = st_i.ref_at_hand;
        cmd_o.evict_rd   = !st_i.ref_at_hand;
      end
      ST_EVICT: begin
        cmd_o.do_evict = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.load_out = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

  `CPR_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE))
  `CPR_ASSERT(a_accept_to_search, (s_valid_i && s_ready_o) |=> (state_q == ST_SEARCH))
  `CPR_ASSERT(a_load_sets_valid, cmd_o.load_out |=> m_valid_q)

endmodule

FILE: sv/clock_page_replacement.sv
// ----------------------------------------------------------------------------
// clock_page_replacement
// second-chance (clock) page replacement over a stream of page references
// ----------------------------------------------------------------------------
// One reference is worked on at a time; a new one is taken while the previous
// result still waits on the output. The frame page memory has one read port,
// so the lookup compares one stored page per cycle: a hit on frame k compares
// frames 0 to k, a miss every filled frame. A replacement then steps the hand
// (at most the frame count of hand steps), clearing set reference bits, and
// reads out the evicted page. No clearing pass follows reset.
module clock_page_replacement #(
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cpr_pkg::CFG_W-1:0]        cfg_wdata_i,    // frames_in_use
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [cpr_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i, // page_number
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // was_hit, frame_index, evicted_valid, evicted_page, hit_total, miss_total
  output logic [cpr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import cpr_pkg::*;

  cmd_t    cmd;
  status_t st;

  cpr_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  cpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .page_i      (s_axis_tdata_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: sim/cpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_checker
// watches the page reference and result streams of the clock page replacement
// block, keeps its own second-chance state, predicts the outcome of every
// accepted reference and compares each result transfer field by field
// ----------------------------------------------------------------------------
module cpr_checker #(
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cpr_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             ref_valid_i,
  input  logic                             ref_ready_i,
  input  logic [cpr_pkg::IN_TDATA_W-1:0]   ref_data_i,
  input  logic                             res_valid_i,
  input  logic                             res_ready_i,
  input  logic [cpr_pkg::OUT_TDATA_W-1:0]  res_data_i,
  output int                               pending_o,
  output int                               errors_o
);

  // packed so that the last field sits in the lowest bits, as on tdata
  typedef struct packed {
    logic [cpr_pkg::TOTAL_W-1:0]     miss_total;
    logic [cpr_pkg::TOTAL_W-1:0]     hit_total;
    logic [cpr_pkg::PAGE_W-1:0]      evicted_page;
    logic                            evicted_valid;
    logic [cpr_pkg::FRAME_OUT_W-1:0] frame_index;
    logic                            was_hit;
  } outcome_t;

  logic [cpr_pkg::PAGE_W-1:0]  frame_page_m [MAX_FRAMES];
  logic                        ref_bits     [MAX_FRAMES];
  int unsigned                 hand_pos;
  int unsigned                 filled_count;
  logic [cpr_pkg::TOTAL_W-1:0] hit_count;
  logic [cpr_pkg::TOTAL_W-1:0] miss_count;
  logic [cpr_pkg::CFG_W-1:0]   frames_reg;

  outcome_t expected_outcomes [$];
  int       error_count;

  function automatic logic [cpr_pkg::TOTAL_W-1:0] bump(logic [cpr_pkg::TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic outcome_t predict_reference(logic [cpr_pkg::PAGE_W-1:0] page);
    int unsigned n;
    int unsigned filled;
    int unsigned idx;
    int unsigned frame;
    int unsigned hand;
    logic        hit;
    outcome_t    r;
    n = 32'(frames_reg);
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    filled = (filled_count < n) ? filled_count : n;
    hit = 1'b0;
    frame = 0;
    r = '0;
    for (idx = 0; idx < filled && !hit; idx++) begin
      if (frame_page_m[idx] == page) begin
        hit = 1'b1;
        frame = idx;
      end
    end
    if (hit) begin
      ref_bits[frame] = 1'b1;
      hit_count = bump(hit_count);
    end else begin
      miss_count = bump(miss_count);
      if (filled < n) begin
        frame = filled;
        filled_count = filled + 1;
      end else begin
        hand = (hand_pos < n) ? hand_pos : 0;
        // second chance: clear set bits until a clear one is met
        while (ref_bits[hand]) begin
          ref_bits[hand] = 1'b0;
          hand = (hand + 1) % n;
        end
        frame = hand;
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page_m[frame];
      end
      frame_page_m[frame] = page;
      ref_bits[frame] = 1'b1;
      hand_pos = (frame + 1) % n;
    end
    r.was_hit = hit;
    r.frame_index = frame[cpr_pkg::FRAME_OUT_W-1:0];
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_r;
    outcome_t got_r;
    if (!rst_ni) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        frame_page_m[k] = '0;
        ref_bits[k] = 1'b0;
      end
      hand_pos = 0;
      filled_count = 0;
      hit_count = '0;
      miss_count = '0;
      frames_reg = cpr_pkg::CFG_RESET;
      expected_outcomes.delete();
      error_count = 0;
    end else begin
      if (cfg_we_i) frames_reg = cfg_wdata_i;
      if (res_valid_i && res_ready_i) begin
        got_r = res_data_i;
        if (expected_outcomes.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result transfer: %h", res_data_i);
          error_count++;
        end else begin
          exp_r = expected_outcomes.pop_front();
          if (got_r.was_hit !== exp_r.was_hit ||
              got_r.frame_index !== exp_r.frame_index ||
              got_r.evicted_valid !== exp_r.evicted_valid ||
              got_r.evicted_page !== exp_r.evicted_page ||
              got_r.hit_total !== exp_r.hit_total ||
              got_r.miss_total !== exp_r.miss_total) begin
            if (error_count < 10) begin
              $display("mismatch exp: hit %0d frame %0d evict %0d page %h hits %0d misses %0d",
                       exp_r.was_hit, exp_r.frame_index, exp_r.evicted_valid,
                       exp_r.evicted_page, exp_r.hit_total, exp_r.miss_total);
              $display("         got: hit %0d frame %0d evict %0d page %h hits %0d misses %0d",
                       got_r.was_hit, got_r.frame_index, got_r.evicted_valid,
                       got_r.evicted_page, got_r.hit_total, got_r.miss_total);
            end
            error_count++;
          end
        end
      end
      if (ref_valid_i && ref_ready_i)
        expected_outcomes.insert(expected_outcomes.size(), predict_reference(ref_data_i));
    end
    pending_o = expected_outcomes.size();
    errors_o = error_count;
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives page references and frame count settings into the clock page
// replacement block under random source and sink idling, with one long sink
// hold-off, and reports the verdict from the checker's error count
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned NUM_PHASES  = 11;
  localparam int unsigned PHASE_ITEMS = 50;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [cpr_pkg::CFG_W-1:0]       cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [cpr_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [cpr_pkg::OUT_TDATA_W-1:0] m_tdata;

  int pending_cnt;
  int error_cnt;
  int send_idle = 8;
  int recv_idle = 52;
  int quiet_cycles = 0;
  logic long_hold_go = 1'b0;
  logic long_hold_done = 1'b0;

  logic [cpr_pkg::CFG_W-1:0] phase_frames [NUM_PHASES] =
    '{7'd64, 7'd5, 7'd1, 7'd17, 7'd3, 7'd100, 7'd8, 7'd0, 7'd33, 7'd127, 7'd2};

  always #1 clk_i = ~clk_i;

  clock_page_replacement #(
    .MAX_FRAMES(64)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  cpr_checker #(
    .MAX_FRAMES(64)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .ref_valid_i(s_tvalid),
    .ref_ready_i(s_tready),
    .ref_data_i (s_tdata),
    .res_valid_i(m_tvalid),
    .res_ready_i(m_tready),
    .res_data_i (m_tdata),
    .pending_o  (pending_cnt),
    .errors_o   (error_cnt)
  );

  // returns at the rising edge of the transfer
  task automatic send_page(input logic [cpr_pkg::PAGE_W-1:0] page);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= page;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic drain_and_configure(input logic [cpr_pkg::CFG_W-1:0] frames);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= frames;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // sink side
  initial begin
    int k;
    forever begin
      @(negedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        for (k = 0; k < 400; k++) begin
          m_tready <= 1'b0;
          @(negedge clk_i);
        end
        long_hold_done = 1'b1;
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int p;
    int i;
    int n_eff;
    int pool_size;
    logic [cpr_pkg::PAGE_W-1:0] page_pool [128];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset frame count, page extremes, hits on first frames
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hA5A5);
    send_page(16'h5A5A);

    // lowered below the filled count, hand beyond it wraps
    drain_and_configure(7'd2);
    send_page(16'h0000);
    send_page(16'h5A5A);
    send_page(16'h1111);
    send_page(16'h2222);
    send_page(16'h0000);
    send_page(16'h2222);

    // zero behaves as one frame
    drain_and_configure(7'd0);
    send_page(16'h3333);
    send_page(16'h3333);
    send_page(16'h4444);

    // above the built capacity, raised while running refills free frames
    drain_and_configure(7'd127);
    send_page(16'h0001);
    send_page(16'h4444);
    send_page(16'hFFFF);
    send_page(16'h8000);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        send_idle = 52;
        recv_idle = 8;
      end
      if (p == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      drain_and_configure(phase_frames[p]);
      n_eff = int'(phase_frames[p]);
      if (n_eff == 0) n_eff = 1;
      if (n_eff > 64) n_eff = 64;
      pool_size = n_eff + n_eff / 2 + 1;
      for (i = 0; i < pool_size; i++) page_pool[i] = 16'($urandom);
      if (p == 1) long_hold_go = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 80) send_page(page_pool[$urandom_range(pool_size - 1)]);
        else send_page(16'($urandom));
      end
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
    if (error_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
